// ----- sv/avfa_pkg.sv -----
// Package with the types, constants and codes of the AVTP video frame assembler.
package avfa_pkg;

	localparam int unsigned CHANNEL_COUNT = 4;
	localparam int unsigned FILL_W = 22;
	localparam int unsigned IN_TDATA_W = 96;
	localparam int unsigned OUT_TDATA_W = 56;
	localparam int unsigned CFG_W = 3;

	localparam logic [15:0] STREAM_BASE = 16'h3350;
	localparam logic [11:0] HEADER_BYTES = 12'd54;
	localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
	localparam logic [4:0] NAL_TYPE_SPS = 5'h07;
	localparam logic [1:0] BUFFER_LAST = 2'd2;
	localparam logic [22:0] BUFFER_BYTES = 23'd2097152;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_WAITING = 3'd1,
		ST_BAD_CHANNEL = 3'd2,
		ST_UNSELECTED = 3'd3,
		ST_TRUNCATED = 3'd4,
		ST_HALTED = 3'd5,
		ST_OVERFLOW = 3'd6
	} status_t;

	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] nal_header;
		logic [7:0] lead_byte3;
		logic [7:0] lead_byte2;
		logic [7:0] lead_byte1;
		logic [7:0] lead_byte0;
		logic [7:0] seq_num;
		logic [15:0] payload_len;
		logic [15:0] stream_id;
		logic [11:0] packet_bytes;
	} in_item_t;

	typedef struct packed {
		logic pad;
		logic [FILL_W-1:0] write_offset;
		logic [1:0] write_buffer;
		logic [FILL_W-1:0] done_length;
		logic [1:0] done_buffer;
		logic frame_done;
		logic seq_error;
		logic [1:0] channel;
		logic [2:0] status;
	} out_item_t;

endpackage

// ----- sv/avtp_video_frame_assembler.sv -----
// Top level of the AVTP video frame assembler, header path of an H.264 receiver.
// One packet header is taken per cycle while the result output is not stalled, and its
// result is registered through the input and result registers; the block sustains one
// transfer per cycle, set by the fill offset, sequence and buffer update between them. A
// truncated packet halts the block until reset, after which every packet reports
// the halted status. The channel select register may be written only while idle.
module avtp_video_frame_assembler (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [avfa_pkg::CFG_W-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: packet_bytes, stream_id, payload_len, seq_num, lead_byte0,
	// lead_byte1, lead_byte2, lead_byte3, nal_header, zero fill.
	input  logic [avfa_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0: status, channel, seq_error, frame_done, done_buffer,
	// done_length, write_buffer, write_offset, zero fill.
	output logic [avfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import avfa_pkg::*;

	logic [CFG_W-1:0] channel_select_q;
	logic halted_q;
	logic started_q;
	logic prev_seq_valid_q;
	logic [7:0] prev_seq_q;
	logic [FILL_W-1:0] fill_offset_q;
	logic [1:0] buffer_index_q;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t result_s2;

	logic advance;
	out_item_t result;
	logic halt_set;
	logic commit;
	logic started_n;
	logic [1:0] buffer_n;
	logic [FILL_W-1:0] fill_n;

	logic [15:0] sid_diff;
	logic [14:0] chan_full;
	logic [16:0] need_bytes;
	logic seq_err;
	logic sps;
	logic release_au;
	logic [FILL_W-1:0] fill_a;
	logic [FILL_W-1:0] fill_b;
	logic [22:0] fill_sum;
	logic [1:0] buffer_next;

	assign cfg_ready = 1'b1;
	assign advance = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = result_s2;

	assign sid_diff = item_s1.stream_id - (STREAM_BASE + 16'd1);
	assign chan_full = sid_diff[15:1];
	assign need_bytes = {5'd0, HEADER_BYTES} + {1'b0, item_s1.payload_len};
	assign seq_err = prev_seq_valid_q && (item_s1.seq_num != prev_seq_q + 8'd1);
	assign sps = (item_s1.lead_byte0 == 8'd0) && (item_s1.lead_byte1 == 8'd0)
		&& (item_s1.lead_byte2 == 8'd0) && (item_s1.lead_byte3 == 8'd1)
		&& ((item_s1.nal_header[4:0] & NAL_TYPE_MASK) == NAL_TYPE_SPS);
	assign fill_a = seq_err ? '0 : fill_offset_q;
	assign release_au = sps && (fill_a != '0);
	assign fill_b = release_au ? '0 : fill_a;
	assign buffer_next = (buffer_index_q == BUFFER_LAST) ? 2'd0 : buffer_index_q + 2'd1;
	assign fill_sum = {1'b0, fill_b} + {7'd0, item_s1.payload_len};

	always_comb begin
		result = '0;
		halt_set = 1'b0;
		commit = 1'b0;
		started_n = started_q || sps;
		buffer_n = release_au ? buffer_next : buffer_index_q;
		fill_n = fill_b;
		if (halted_q) begin
			result.status = ST_HALTED;
		end else if (item_s1.packet_bytes < HEADER_BYTES) begin
			result.status = ST_TRUNCATED;
			halt_set = 1'b1;
		end else if (item_s1.stream_id < STREAM_BASE + 16'd1
				|| chan_full >= 15'(CHANNEL_COUNT)) begin
			result.status = ST_BAD_CHANNEL;
		end else begin
			result.channel = chan_full[1:0];
			if (!channel_select_q[CFG_W-1] && {12'd0, channel_select_q} != chan_full) begin
				result.status = ST_UNSELECTED;
			end else if ({5'd0, item_s1.packet_bytes} < need_bytes) begin
				result.status = ST_TRUNCATED;
				halt_set = 1'b1;
			end else begin
				commit = 1'b1;
				result.seq_error = seq_err;
				if (release_au) begin
					result.frame_done = 1'b1;
					result.done_buffer = buffer_index_q;
					result.done_length = fill_a;
				end
				if (!started_n) begin
					result.status = ST_WAITING;
				end else begin
					result.write_buffer = buffer_n;
					result.write_offset = fill_b;
					if (fill_sum > BUFFER_BYTES) begin
						result.status = ST_OVERFLOW;
					end else begin
						result.status = ST_STORED;
						fill_n = fill_sum[FILL_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_select_q <= '1;
			halted_q <= 1'b0;
			started_q <= 1'b0;
			prev_seq_valid_q <= 1'b0;
			prev_seq_q <= '0;
			fill_offset_q <= '0;
			buffer_index_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				channel_select_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				if (halt_set) begin
					halted_q <= 1'b1;
				end
				if (commit) begin
					started_q <= started_n;
					prev_seq_valid_q <= 1'b1;
					prev_seq_q <= item_s1.seq_num;
					fill_offset_q <= fill_n;
					buffer_index_q <= buffer_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata;
		end
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

endmodule

// ----- sv/avfa_checker.sv -----
// Port checker for the AVTP video frame assembler and its bind to the top level.
module avfa_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [avfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import avfa_pkg::*;

	out_item_t res;
	assign res = m_axis_tdata;

	// A stalled result transfer keeps its valid and its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Only a stored, waiting or overflowed packet can release an access unit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.frame_done |->
		res.status == ST_STORED || res.status == ST_WAITING || res.status == ST_OVERFLOW)
		else $error("frame release on a dropped packet");

	// Release fields are zero when no access unit is released.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.frame_done |-> res.done_buffer == '0 && res.done_length == '0)
		else $error("release fields set without a release");

	// A write location is given only for stored or overflowed packets.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status != ST_STORED && res.status != ST_OVERFLOW |->
		res.write_buffer == '0 && res.write_offset == '0)
		else $error("write location on an unstored packet");

endmodule

bind avtp_video_frame_assembler avfa_checker u_avfa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
